// ----- sv/bitmap_address_and_shifter_regs_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Bitmap address and shifter register unit - assertion macros
// Shared concurrent assertion wrappers, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BITMAP_ADDRESS_AND_SHIFTER_REGS_UNIT_DEFINES_SVH
`define BITMAP_ADDRESS_AND_SHIFTER_REGS_UNIT_DEFINES_SVH

// same-cycle implication
`define BMSR_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BMSR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/bmsr_pkg.sv -----
// ----------------------------------------------------------------------------
// bmsr_pkg
// Command codes, constants and the request struct of the register unit.
// ----------------------------------------------------------------------------
package bmsr_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned AMOUNT_W = 3;
	localparam logic [BYTE_W-1:0] VRAM_BASE_HI = 8'h40; // 0x4000 >> 8

	typedef enum logic [2:0] {
		CMD_WR_ROW    = 3'd0,
		CMD_WR_COL    = 3'd1,
		CMD_WR_SHIFT  = 3'd2,
		CMD_RD_ROW    = 3'd3,
		CMD_RD_ADDRHI = 3'd4,
		CMD_RD_ADDRLO = 3'd5,
		CMD_RD_SHIFT  = 3'd6,
		CMD_RD_SHREV  = 3'd7
	} cmd_t;

	// one bus word presented to the register core
	typedef struct packed {
		logic              exec;
		cmd_t              cmd;
		logic [BYTE_W-1:0] wdata;
	} req_t;

endpackage

// ----- sv/bmsr_core.sv -----
// ----------------------------------------------------------------------------
// bmsr_core
// Row, column and shifter registers plus the read-data mux.
// ----------------------------------------------------------------------------
`include "bitmap_address_and_shifter_regs_unit_defines.svh"

module bmsr_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bmsr_pkg::req_t              req,
	output logic [bmsr_pkg::BYTE_W-1:0] rdata
);
	import bmsr_pkg::*;

	logic [BYTE_W-1:0]   row_q;
	logic [BYTE_W-1:0]   col_q;
	logic [2*BYTE_W-1:0] shift_q;
	logic [AMOUNT_W-1:0] amount;
	logic [3:0]          win_shift;
	logic [2*BYTE_W-1:0] shifted;
	logic [BYTE_W-1:0]   window;
	logic [BYTE_W-1:0]   window_rev;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= '0;
			col_q   <= '0;
			shift_q <= '0;
		end else if (req.exec) begin
			case (req.cmd)
				CMD_WR_ROW: begin
					row_q   <= req.wdata;
					shift_q <= {{BYTE_W{1'b0}}, shift_q[2*BYTE_W-1:BYTE_W]};
				end
				CMD_WR_COL: begin
					col_q <= req.wdata;
				end
				CMD_WR_SHIFT: begin
					shift_q <= {req.wdata, shift_q[2*BYTE_W-1:BYTE_W]};
				end
				default: begin
				end
			endcase
		end
	end

	// window = shift >> (8 - amount); shift amount ranges 1..8
	assign amount    = col_q[AMOUNT_W-1:0];
	assign win_shift = 4'd8 - {1'b0, amount};
	assign shifted   = shift_q >> win_shift;
	assign window    = shifted[BYTE_W-1:0];

	always_comb begin
		for (int i = 0; i < BYTE_W; i++) begin
			window_rev[i] = window[BYTE_W-1-i];
		end
	end

	always_comb begin
		case (req.cmd)
			CMD_WR_ROW, CMD_WR_COL, CMD_WR_SHIFT: rdata = '0;
			CMD_RD_ROW:    rdata = row_q;
			CMD_RD_ADDRHI: rdata = VRAM_BASE_HI | {3'b000, row_q[7:3]};
			CMD_RD_ADDRLO: rdata = {row_q[2:0], col_q[7:3]};
			CMD_RD_SHIFT:  rdata = window;
			CMD_RD_SHREV:  rdata = window_rev;
			default:       rdata = '0;
		endcase
	end

	// row write drops the high byte into the low byte and clears the top
	`BMSR_ASSERT_NEXT(a_row_wr_clears_hi, req.exec && req.cmd == CMD_WR_ROW, shift_q[15:8] == 8'h00, "row write left shifter high byte set")
	// shifter write pushes the old high byte down
	`BMSR_ASSERT_NEXT(a_shift_wr_push, req.exec && req.cmd == CMD_WR_SHIFT, shift_q[7:0] == $past(shift_q[15:8]) && shift_q[15:8] == $past(req.wdata), "shifter push mismatch")
	// zero amount reads back the high byte
	`BMSR_ASSERT_SAME(a_zero_amount, col_q[2:0] == 3'd0, window == shift_q[15:8], "zero-amount window is not the high byte")

endmodule

// ----- sv/bitmap_address_and_shifter_regs_unit.sv -----
// ----------------------------------------------------------------------------
// bitmap_address_and_shifter_regs_unit
// Bus register block for a bitmap video helper: address former and shifter.
// ----------------------------------------------------------------------------
// Each input word is one bus access (cmd, wdata) and produces exactly one
// output word (rdata; zero for writes). The unit keeps a row register, a
// column register and a 16-bit shifter. Reads return the row, the high or
// low byte of the bitmap address 0x4000 | row<<5 | col>>3, or the byte
// shifter >> (8 - col[2:0]), plain or bit-reversed. A row write also shifts
// the shifter down by one byte; a shifter write pushes wdata in on top.
// Throughput is one word per clock while out_ready keeps the output free: a
// word is captured in the input stage, executed there against the registers
// (reads see every earlier write), and its result lands in the output
// register. The input and output stages stall independently, so a new word
// is taken while a finished result still waits for out_ready, as long as the
// input stage is empty; with both stages full and out_ready low the input stalls.
// ----------------------------------------------------------------------------
`include "bitmap_address_and_shifter_regs_unit_defines.svh"

module bitmap_address_and_shifter_regs_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [2:0]                  cmd,
	input  logic [bmsr_pkg::BYTE_W-1:0] wdata,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [bmsr_pkg::BYTE_W-1:0] rdata
);
	import bmsr_pkg::*;

	// input stage
	logic              valid_s1;
	cmd_t              cmd_s1;
	logic [BYTE_W-1:0] wdata_s1;

	// output stage
	logic              out_valid_q;
	logic [BYTE_W-1:0] rdata_q;

	logic              out_free;
	logic              adv_s1;
	logic              is_write_s1;
	req_t              req;
	logic [BYTE_W-1:0] core_rdata;

	assign out_free = !out_valid_q || out_ready;
	assign adv_s1   = valid_s1 && out_free;   // word executes and retires s1
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1   <= cmd_t'(cmd);
			wdata_s1 <= wdata;
		end
	end

	assign req.exec  = adv_s1;
	assign req.cmd   = cmd_s1;
	assign req.wdata = wdata_s1;

	bmsr_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rdata  (core_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rdata_q <= core_rdata;
		end
	end

	assign out_valid = out_valid_q;
	assign rdata     = rdata_q;

	assign is_write_s1 = cmd_s1 inside {CMD_WR_ROW, CMD_WR_COL, CMD_WR_SHIFT};

	// a full input stage facing a stalled output must back-pressure
	`BMSR_ASSERT_SAME(a_stall_blocks_in, valid_s1 && out_valid_q && !out_ready, !in_ready, "input accepted while both stages are full")
	// a word leaving s1 always shows up at the output
	`BMSR_ASSERT_NEXT(a_adv_to_out, adv_s1, out_valid_q, "executed word did not reach the output")
	// writes answer with zero
	`BMSR_ASSERT_NEXT(a_write_zero, adv_s1 && is_write_s1, rdata_q == 8'h00, "write returned nonzero data")

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench - bitmap address and shifter register unit
// Drives bus words (cmd, wdata) through the valid/ready input, collects rdata
// words from the output, and checks each against a cycle-free model of the
// row, column and shifter registers. The run goes through phases of sender
// idling and receiver stalling, with one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
	import bmsr_pkg::*;

	localparam int unsigned ROW_SHIFT   = 5;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned DRAIN_WAIT  = 8;  // margin for stray words after the queue drains
	localparam int unsigned HOLD_CYCLES = 60;
	localparam int unsigned RAND_WORDS  = 100; // per random phase

	// Register model of the unit plus the queue of rdata bytes still owed.
	class access_scoreboard;
		logic [BYTE_W-1:0] row_m;
		logic [BYTE_W-1:0] col_m;
		logic [15:0]       shifter_m;
		logic [BYTE_W-1:0] rdata_owed[$];
		int unsigned       mismatches;

		function new();
			row_m      = '0;
			col_m      = '0;
			shifter_m  = '0;
			mismatches = 0;
		endfunction

		function logic [BYTE_W-1:0] window_byte();
			int unsigned amount;
			amount = int'(col_m[AMOUNT_W-1:0]);
			return BYTE_W'(shifter_m >> (8 - amount));
		endfunction

		function logic [15:0] bitmap_addr();
			return {VRAM_BASE_HI, 8'h00} | (16'(row_m) << ROW_SHIFT) | 16'(col_m >> 3);
		endfunction

		// Accepted input word: update the registers, queue the byte it reads back.
		function void note_access(cmd_t c, logic [BYTE_W-1:0] w);
			logic [BYTE_W-1:0] rd;
			logic [BYTE_W-1:0] win;
			logic [15:0]       addr;
			rd   = '0;
			addr = bitmap_addr();
			case (c)
				CMD_WR_ROW: begin
					row_m     = w;
					shifter_m = shifter_m >> 8;
				end
				CMD_WR_COL: begin
					col_m = w;
				end
				CMD_WR_SHIFT: begin
					shifter_m = {w, shifter_m[15:8]};
				end
				CMD_RD_ROW:    rd = row_m;
				CMD_RD_ADDRHI: rd = addr[15:8];
				CMD_RD_ADDRLO: rd = addr[7:0];
				CMD_RD_SHIFT:  rd = window_byte();
				default: begin
					win = window_byte();
					for (int i = 0; i < BYTE_W; i++)
						rd[BYTE_W-1-i] = win[i];
				end
			endcase
			rdata_owed.push_back(rd);
		endfunction

		task report(string msg);
			$display("ERROR: %s", msg);
			mismatches++;
		endtask

		task check_rdata(logic [BYTE_W-1:0] got);
			logic [BYTE_W-1:0] want;
			if (rdata_owed.size() == 0) begin
				report($sformatf("unexpected rdata word 0x%02h", got));
			end else begin
				want = rdata_owed.pop_front();
				if (got !== want)
					report($sformatf("rdata 0x%02h, expected 0x%02h", got, want));
			end
		endtask

		task check_drained();
			if (rdata_owed.size() != 0)
				report($sformatf("%0d rdata words never arrived", rdata_owed.size()));
		endtask

		function int unsigned pending();
			return rdata_owed.size();
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [2:0]        cmd;
	logic [BYTE_W-1:0] wdata;
	logic              out_valid;
	logic              out_ready;
	logic [BYTE_W-1:0] rdata;

	access_scoreboard sb = new();

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	logic        hold_on;
	int unsigned cycle_count;

	bitmap_address_and_shifter_regs_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.wdata    (wdata),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.rdata    (rdata)
	);

	initial begin
		clk = 1'b0;
	end

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Offer one word; idle first at the current rate, then hold valid until taken.
	// Valid stays high after acceptance so back-to-back words see no bubble.
	task push_access(input cmd_t c, input logic [BYTE_W-1:0] w);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= c;
		wdata    <= w;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_access(c, w);
	endtask

	// Receiver: sample a word at the edge, then pick out_ready for the next one.
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				sb.check_rdata(rdata);
			if (hold_on)
				out_ready <= 1'b0;
			else
				out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	initial begin
		logic [BYTE_W-1:0] w;
		int unsigned       sel;

		arst_n         = 1'b0;
		in_valid       = 1'b0;
		cmd            = CMD_WR_ROW;
		wdata          = '0;
		out_ready      = 1'b0;
		hold_on        = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		cycle_count    = 0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every read straight out of reset (wdata ignored on reads)
		push_access(CMD_RD_ROW,    8'hFF);
		push_access(CMD_RD_ADDRHI, 8'hFF);
		push_access(CMD_RD_ADDRLO, 8'hFF);
		push_access(CMD_RD_SHIFT,  8'hFF);
		push_access(CMD_RD_SHREV,  8'hFF);
		// two shifter pushes; zero amount reads back the high byte
		push_access(CMD_WR_SHIFT,  8'hA5);
		push_access(CMD_WR_SHIFT,  8'h3C);
		push_access(CMD_RD_SHIFT,  8'h00);
		// largest amount, plain and reversed
		push_access(CMD_WR_COL,    8'h07);
		push_access(CMD_RD_SHIFT,  8'h00);
		push_access(CMD_RD_SHREV,  8'h00);
		// column and row at full scale: row bits fill both address bytes
		push_access(CMD_WR_COL,    8'hFF);
		push_access(CMD_WR_ROW,    8'hFF);
		push_access(CMD_RD_ROW,    8'h00);
		push_access(CMD_RD_ADDRHI, 8'h00);
		push_access(CMD_RD_ADDRLO, 8'h00);
		// row write dropped the shifter by a byte
		push_access(CMD_RD_SHIFT,  8'h00);
		push_access(CMD_RD_SHREV,  8'h00);
		push_access(CMD_WR_ROW,    8'h00);
		push_access(CMD_WR_COL,    8'h00);
		push_access(CMD_RD_ADDRHI, 8'h00);
		push_access(CMD_RD_ADDRLO, 8'h00);
		push_access(CMD_WR_SHIFT,  8'hFF);
		push_access(CMD_WR_SHIFT,  8'h01);
		push_access(CMD_RD_SHREV,  8'h00);

		// Random phases: no idling, sender idle, receiver stalling, both.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct  <= 0;
					recv_stall_pct <= 0;
					// long output hold-off while the sender keeps going
					fork
						begin
							hold_on <= 1'b1;
							repeat (HOLD_CYCLES) @(posedge clk);
							hold_on <= 1'b0;
						end
					join_none
				end
				1: begin
					send_idle_pct  <= 65;
					recv_stall_pct <= 0;
				end
				2: begin
					send_idle_pct  <= 0;
					recv_stall_pct <= 65;
				end
				default: begin
					send_idle_pct  <= 20;
					recv_stall_pct <= 20;
				end
			endcase
			for (int n = 0; n < RAND_WORDS; n++) begin
				sel = $urandom_range(0, 7);
				if (sel == 0)
					w = 8'h00;
				else if (sel == 1)
					w = 8'hFF;
				else
					w = BYTE_W'($urandom);
				push_access(cmd_t'($urandom_range(0, 7)), w);
			end
		end
		in_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		sb.check_drained();

		if (sb.mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
